// ===== src/b64u_pkg.sv =====
// Shared constants and types for the URL-variant base64 decoder.
`timescale 1ns / 1ps

package b64u_pkg;

    // Record geometry.
    localparam int RECORD_BYTES     = 18;
    localparam int CHARS_PER_RECORD = (RECORD_BYTES * 8 + 5) / 6;
    localparam int POS_CLOG         = $clog2(CHARS_PER_RECORD);
    localparam int POS_W            = (POS_CLOG < 2) ? 2 : POS_CLOG;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHARS_PER_RECORD - 1);

    // Character field widths.
    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int BYTE_W   = 8;

    // Alphabet range bounds, and the two characters outside the letter and digit ranges.
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_AT      = 8'h40;
    localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;

    // Offsets that turn a character into its sextet value.
    localparam logic [CHAR_W-1:0] OFS_UPPER = 8'd65;   // 'A' -> 0
    localparam logic [CHAR_W-1:0] OFS_LOWER = 8'd71;   // 'a' -> 26
    localparam logic [CHAR_W-1:0] OFS_DIGIT = 8'd4;    // '0' -> 52, added
    localparam logic [SEXTET_W-1:0] SEXTET_AT   = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_DASH = 6'd63;

    // Position of a character within its group of four.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;
    localparam logic [1:0] PHASE_FOURTH = 2'd3;

    // Result of packing one character.
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_record;
        logic              bad_char;
    } pack_result_t;

endpackage

// ===== src/b64u_sextet_map.sv =====
// Alphabet lookup: one character to its 6-bit value and an out-of-alphabet flag.
`timescale 1ns / 1ps

module b64u_sextet_map (
    input  logic [b64u_pkg::CHAR_W-1:0]   code_char,
    output logic [b64u_pkg::SEXTET_W-1:0] sextet,
    output logic                          bad
);

    logic [b64u_pkg::CHAR_W-1:0] upper_val;
    logic [b64u_pkg::CHAR_W-1:0] lower_val;
    logic [b64u_pkg::CHAR_W-1:0] digit_val;

    assign upper_val = code_char - b64u_pkg::OFS_UPPER;
    assign lower_val = code_char - b64u_pkg::OFS_LOWER;
    assign digit_val = code_char + b64u_pkg::OFS_DIGIT;

    // Range checks in alphabet order; anything else decodes as zero.
    always_comb begin
        sextet = '0;
        bad    = 1'b0;
        priority if (code_char >= b64u_pkg::CHAR_UPPER_A &&
                     code_char <= b64u_pkg::CHAR_UPPER_Z) begin
            sextet = upper_val[b64u_pkg::SEXTET_W-1:0];
        end else if (code_char >= b64u_pkg::CHAR_LOWER_A &&
                     code_char <= b64u_pkg::CHAR_LOWER_Z) begin
            sextet = lower_val[b64u_pkg::SEXTET_W-1:0];
        end else if (code_char >= b64u_pkg::CHAR_DIGIT_0 &&
                     code_char <= b64u_pkg::CHAR_DIGIT_9) begin
            sextet = digit_val[b64u_pkg::SEXTET_W-1:0];
        end else if (code_char == b64u_pkg::CHAR_AT) begin
            sextet = b64u_pkg::SEXTET_AT;
        end else if (code_char == b64u_pkg::CHAR_DASH) begin
            sextet = b64u_pkg::SEXTET_DASH;
        end else begin
            bad = 1'b1;
        end
    end

endmodule

// ===== src/b64u_packer.sv =====
// Record state and bit packing of sextets into bytes.
`timescale 1ns / 1ps

module b64u_packer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [b64u_pkg::SEXTET_W-1:0] sextet,
    input  logic                          bad,
    output b64u_pkg::pack_result_t        result
);

    logic [b64u_pkg::SEXTET_W-1:0] prev_sextet_reg;
    logic [b64u_pkg::SEXTET_W-1:0] prev_sextet_next;
    logic [b64u_pkg::POS_W-1:0]    char_pos_reg;
    logic [b64u_pkg::POS_W-1:0]    char_pos_next;
    logic                          error_seen_reg;
    logic                          error_seen_next;
    logic                          is_last;
    logic                          err_now;
    logic [1:0]                    phase;

    assign phase   = char_pos_reg[1:0];
    assign is_last = (char_pos_reg == b64u_pkg::POS_LAST);
    assign err_now = error_seen_reg | bad;

    // Byte formation from the previous and current sextets.
    always_comb begin
        result.emit           = 1'b1;
        result.last_of_record = is_last;
        result.bad_char       = err_now;
        unique case (phase)
            b64u_pkg::PHASE_FIRST: begin
                result.emit      = 1'b0;
                result.data_byte = '0;
            end
            b64u_pkg::PHASE_SECOND: begin
                result.data_byte = {prev_sextet_reg, sextet[5:4]};
            end
            b64u_pkg::PHASE_THIRD: begin
                result.data_byte = {prev_sextet_reg[3:0], sextet[5:2]};
            end
            b64u_pkg::PHASE_FOURTH: begin
                result.data_byte = {prev_sextet_reg[1:0], sextet};
            end
            default: begin
                result.emit      = 1'b0;
                result.data_byte = '0;
            end
        endcase
    end

    // Next state: advance within the record or wrap at its end.
    always_comb begin
        prev_sextet_next = prev_sextet_reg;
        char_pos_next    = char_pos_reg;
        error_seen_next  = error_seen_reg;
        if (step) begin
            prev_sextet_next = sextet;
            if (is_last) begin
                char_pos_next   = '0;
                error_seen_next = 1'b0;
            end else begin
                char_pos_next   = char_pos_reg + 1'b1;
                error_seen_next = err_now;
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sextet_reg <= '0;
            char_pos_reg    <= '0;
            error_seen_reg  <= 1'b0;
        end else begin
            prev_sextet_reg <= prev_sextet_next;
            char_pos_reg    <= char_pos_next;
            error_seen_reg  <= error_seen_next;
        end
    end

`ifndef SYNTHESIS
    // The position never runs past the record.
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        char_pos_reg <= b64u_pkg::POS_LAST)
        else $error("character position beyond record");

    // Finishing a record clears the position and the sticky error.
    a_record_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        step && is_last |=> char_pos_reg == '0 && !error_seen_reg)
        else $error("record end did not restart state");

    // The last character of a record always yields a byte.
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        is_last |-> result.emit)
        else $error("record ends on a group's first character");
`endif

endmodule

// ===== src/base64_url_variant_decoder.sv =====
// Top level: stream ports, input register, decode and packing, output register.
// Path: an accepted input character passes the input register, the lookup and packing,
// and the output register. Throughput: one character per cycle while the output is
// not stalled; the first character of each group of four gives no output, the others
// one byte each.
// Reset: synchronous active-low aresetn empties both registers and restarts the record.
`timescale 1ns / 1ps

module base64_url_variant_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] code_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast,   // last_of_record
    output logic       m_tuser    // [0] bad_char
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [b64u_pkg::CHAR_W-1:0]   in_char_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [b64u_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          out_last_reg;
    logic                          out_bad_reg;
    logic                          out_free;
    logic                          step;
    logic                          s_fire;
    logic [b64u_pkg::SEXTET_W-1:0] sextet;
    logic                          bad;
    b64u_pkg::pack_result_t        result;

    // Handshake: the decode stage moves on whenever it holds a character and the output slot can take a result.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    b64u_sextet_map u_map (
        .code_char (in_char_reg),
        .sextet    (sextet),
        .bad       (bad)
    );

    b64u_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .sextet  (sextet),
        .bad     (bad),
        .result  (result)
    );

    // Valid flags of both stages.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = result.emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_char_reg <= s_tdata;
        end
        if (step && result.emit) begin
            out_byte_reg <= result.data_byte;
            out_last_reg <= result.last_of_record;
            out_bad_reg  <= result.bad_char;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

`ifndef SYNTHESIS
    // Both stages come out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // Input is refused only while a character waits in the input register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && !out_free)
        else $error("input refused without a blocked character");

    // A stalled output result is not overwritten by a new step.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !step)
        else $error("decode stage advanced into a full output register");
`endif

endmodule

// ===== tb/b64u_decode_monitor.sv =====
// Checker for the URL-variant base64 decoder: predicts each output byte and compares it.
`timescale 1ns / 1ps

module b64u_decode_monitor
    import b64u_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] code_char
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] data_byte
    input  logic       m_tlast,   // last_of_record
    input  logic       m_tuser,   // [0] bad_char
    output int         fail_count,
    output int         bytes_due
);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_record;
        logic              bad_char;
    } decoded_byte_t;

    // Predictor state: value of the previous character, place in the record, sticky error.
    logic [SEXTET_W-1:0] prev_value;
    int unsigned         char_index;
    logic                err_sticky;
    decoded_byte_t       byte_queue[$];
    int                  mismatches;

    // Map a character onto the alphabet; anything outside it counts as zero and is flagged.
    function automatic logic [SEXTET_W-1:0] alphabet_value(input logic [CHAR_W-1:0] ch,
                                                           output logic bad);
        bad = 1'b0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) return SEXTET_W'(ch - CHAR_UPPER_A);
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) return SEXTET_W'(ch - CHAR_LOWER_A + 26);
        if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) return SEXTET_W'(ch - CHAR_DIGIT_0 + 52);
        if (ch == CHAR_AT) return SEXTET_AT;
        if (ch == CHAR_DASH) return SEXTET_DASH;
        bad = 1'b1;
        return '0;
    endfunction

    // Advance the predictor by one character; returns 1 when the character completes a byte.
    function automatic bit decode_char(input logic [CHAR_W-1:0] ch, output decoded_byte_t res);
        logic                bad;
        logic [SEXTET_W-1:0] cur;
        logic [1:0]          phase;
        logic                err;
        bit                  rec_end;
        bit                  emit;
        cur     = alphabet_value(ch, bad);
        phase   = 2'(char_index);
        err     = err_sticky | bad;
        rec_end = (char_index + 1 >= CHARS_PER_RECORD);
        emit    = 1'b1;
        res     = '0;
        case (phase)
            PHASE_SECOND: res.data_byte = {prev_value, cur[5:4]};
            PHASE_THIRD:  res.data_byte = {prev_value[3:0], cur[5:2]};
            PHASE_FOURTH: res.data_byte = {prev_value[1:0], cur};
            default:      emit = 1'b0;
        endcase
        res.last_of_record = rec_end;
        res.bad_char       = err;
        prev_value = cur;
        if (rec_end) begin
            char_index = 0;
            err_sticky = 1'b0;
        end else begin
            char_index = char_index + 1;
            err_sticky = err;
        end
        return emit;
    endfunction

    // Check output transfers against the oldest expectation, then predict from input transfers.
    always @(posedge aclk) begin
        decoded_byte_t got;
        decoded_byte_t want;
        if (!aresetn) begin
            prev_value = '0;
            char_index = 0;
            err_sticky = 1'b0;
            mismatches = 0;
            byte_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{data_byte: m_tdata, last_of_record: m_tlast, bad_char: m_tuser};
                if (byte_queue.size() == 0) begin
                    $error("unexpected output transfer: data_byte 0x%02h", m_tdata);
                    mismatches++;
                end else begin
                    want = byte_queue.pop_front();
                    if (got.data_byte !== want.data_byte) begin
                        $error("data_byte: expected 0x%02h, got 0x%02h",
                               want.data_byte, got.data_byte);
                        mismatches++;
                    end
                    if (got.last_of_record !== want.last_of_record) begin
                        $error("last_of_record: expected %0b, got %0b",
                               want.last_of_record, got.last_of_record);
                        mismatches++;
                    end
                    if (got.bad_char !== want.bad_char) begin
                        $error("bad_char: expected %0b, got %0b", want.bad_char, got.bad_char);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (decode_char(s_tdata, want)) byte_queue.push_back(want);
            end
        end
        fail_count <= mismatches;
        bytes_due  <= byte_queue.size();
    end

endmodule

// ===== tb/base64_url_variant_decoder_tb.sv =====
// Testbench top: clock, reset, character stimulus, receiver pacing and the final verdict.
`timescale 1ns / 1ps

module base64_url_variant_decoder_tb;
    import b64u_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_RECORDS = 46;
    localparam int CALM_RECORDS   = 10;
    localparam int HOLD_OFF_CYCLES = 64;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] code_char
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] data_byte
    logic       m_tlast;    // last_of_record
    logic       m_tuser;    // [0] bad_char

    int fail_count;
    int bytes_due;
    int cycle_count = 0;
    bit idle_on = 1'b1;
    bit hold_off_req = 1'b0;

    base64_url_variant_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    b64u_decode_monitor monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .bytes_due  (bytes_due)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("base64_url_variant_decoder_tb: errors");
            $finish;
        end
    end

    // Character that encodes a given 6-bit value.
    function automatic logic [CHAR_W-1:0] alphabet_char(input logic [SEXTET_W-1:0] v);
        if (v < 26) return CHAR_UPPER_A + CHAR_W'(v);
        if (v < 52) return CHAR_LOWER_A + CHAR_W'(v - 26);
        if (v < 62) return CHAR_DIGIT_0 + CHAR_W'(v - 52);
        if (v == SEXTET_AT) return CHAR_AT;
        return CHAR_DASH;
    endfunction

    // Offer one character and hold it until the transfer happens, sometimes after a gap.
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Receiver pacing: random stall bursts, one long hold-off on request.
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [CHAR_W-1:0] directed[] = '{
            CHAR_UPPER_A, CHAR_UPPER_Z, CHAR_LOWER_A, CHAR_LOWER_Z,
            CHAR_DIGIT_0, CHAR_DIGIT_9, CHAR_AT,      CHAR_DASH,
            CHAR_DASH,    CHAR_DASH,    CHAR_DASH,    CHAR_DASH,
            CHAR_UPPER_A, CHAR_UPPER_A, CHAR_UPPER_A, CHAR_UPPER_A,
            8'h00,        8'h3F,        8'h5B,        8'h60,
            8'h7B,        8'h2C,        8'h2E,        8'hFF
        };
        int mode;
        logic [CHAR_W-1:0] ch;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed record: alphabet edges, all-ones and all-zero bytes, then bad characters
        // starting on the first character of a group and ending on the record's last one.
        foreach (directed[i]) send_char(directed[i]);

        // Random records, mostly clean; the receiver holds off early while input keeps coming.
        for (int r = 0; r < RANDOM_RECORDS; r++) begin
            if (r == 2) hold_off_req = 1'b1;
            if (r == RANDOM_RECORDS - CALM_RECORDS) idle_on = 1'b0;
            mode = $urandom_range(0, 7);
            for (int c = 0; c < CHARS_PER_RECORD; c++) begin
                if (mode == 7 || (mode == 6 && $urandom_range(0, 5) == 0))
                    ch = CHAR_W'($urandom_range(0, 255));
                else
                    ch = alphabet_char(SEXTET_W'($urandom_range(0, 63)));
                send_char(ch);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then keep watching for any stray output before the verdict.
        @(posedge aclk);
        while (bytes_due != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0) begin
            $display("base64_url_variant_decoder_tb: clean");
        end else begin
            $display("base64_url_variant_decoder_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/b64u_pkg.sv
src/b64u_sextet_map.sv
src/b64u_packer.sv
src/base64_url_variant_decoder.sv
tb/b64u_decode_monitor.sv
tb/base64_url_variant_decoder_tb.sv
